### rtl/bed_pkg.sv
// shared types, constants and decode helpers of the backslash escape decoder
// no dependencies
package bed_pkg;

  // register indexes of the configuration port
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] RegInterpret = 2'd0;
  localparam logic [CfgIdxW-1:0] RegNewline   = 2'd1;

  // default depth of the run queue between front and back
  localparam int unsigned QueueDepth = 4;

  // most bytes a single item can produce
  localparam int unsigned MaxRun = 3;

  // byte codes
  localparam logic [7:0] ChBackslash = 8'h5C;
  localparam logic [7:0] ChSpace     = 8'h20;
  localparam logic [7:0] ChNewline   = 8'h0A;
  localparam logic [7:0] ChEsc       = 8'h1B;
  localparam logic [7:0] ChStop      = 8'h63; // c
  localparam logic [7:0] ChOctal     = 8'h30; // 0
  localparam logic [7:0] ChHex       = 8'h78; // x

  // digit counts of the numeric escapes
  localparam logic [1:0] OctDigits = 2'd3;
  localparam logic [1:0] HexDigits = 2'd2;

  // configuration write beat
  typedef struct packed {
    logic               valid;
    logic [CfgIdxW-1:0] index;
    logic               data;
  } cfg_wr_t;

  // one run: the bytes caused by one input item
  typedef struct packed {
    logic [1:0]             cnt;   // 1 to 3 bytes
    logic [MaxRun-1:0][7:0] bytes;
    logic                   done;  // run closes the message
  } run_t;

  // digit lookup for octal or hex escapes
  typedef struct packed {
    logic       hit;
    logic [3:0] val;
  } digit_t;

  function automatic digit_t digit_value(input logic [7:0] b, input logic hex);
    digit_t r;
    r.hit = 1'b0;
    r.val = 4'd0;
    if (hex) begin
      if (b inside {[8'h30:8'h39]}) begin
        r.hit = 1'b1;
        r.val = b[3:0];
      end else if (b inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
        r.hit = 1'b1;
        r.val = b[3:0] + 4'd9;
      end
    end else if (b inside {[8'h30:8'h37]}) begin
      r.hit = 1'b1;
      r.val = {1'b0, b[2:0]};
    end
    return r;
  endfunction

  // single-letter control escapes, backslash included
  typedef struct packed {
    logic       hit;
    logic [7:0] val;
  } ctrl_t;

  function automatic ctrl_t ctrl_letter(input logic [7:0] b);
    ctrl_t r;
    r.hit = 1'b1;
    case (b)
      ChBackslash: r.val = ChBackslash;
      8'h61:       r.val = 8'h07; // a
      8'h62:       r.val = 8'h08; // b
      8'h65:       r.val = ChEsc; // e
      8'h66:       r.val = 8'h0C; // f
      8'h6E:       r.val = 8'h0A; // n
      8'h72:       r.val = 8'h0D; // r
      8'h74:       r.val = 8'h09; // t
      8'h76:       r.val = 8'h0B; // v
      default: begin
        r.hit = 1'b0;
        r.val = b;
      end
    endcase
    return r;
  endfunction

endpackage

### rtl/backslash_escape_decoder.sv
// top level of the backslash escape decoder
// depends on bed_pkg, bed_front, bed_queue, bed_back
//
// Input channel: an item (has_byte, data_byte, arg_end, message_end) is taken
// on a clock edge with push high and full low. Every item is decoded in the
// cycle it is taken, so one item per cycle goes in while the run queue has room.
// Result channel: while empty is low the oldest byte sits on out_byte_o with
// last_of_run_o and message_done_o; it is taken on an edge with pop high.
// The run of a taken item is registered in the run queue before its first byte reaches out_byte_o.
// An item yields zero to three bytes; the result side moves one byte per cycle
// while pop is high, so an item of several bytes holds the back end longer and
// the run queue (QueueDepth runs) soaks up the difference until full rises.
// When the receiver stalls, the queue fills and full holds off the sender.
// Config writes (cfg_valid_i, always ready) must be made while idle (not enforced);
// index 0 turns escape decoding on, index 1 turns the closing newline on.
// Reset clears escape state and the queue, turns decoding off and the
// newline on; it takes effect at once and needs no clearing pass.
module backslash_escape_decoder #(
  parameter int unsigned QueueDepth = bed_pkg::QueueDepth
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [bed_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic                        cfg_data_i,
  input  logic                        push,
  output logic                        full,
  input  logic                        has_byte_i,
  input  logic [7:0]                  data_byte_i,
  input  logic                        arg_end_i,
  input  logic                        message_end_i,
  output logic                        empty,
  input  logic                        pop,
  output logic [7:0]                  out_byte_o,
  output logic                        last_of_run_o,
  output logic                        message_done_o
);

  bed_pkg::cfg_wr_t cfg;
  bed_pkg::run_t    wr_run, head_run;
  logic             accept, run_valid, run_pop, run_empty;

  assign cfg_ready_o = 1'b1;
  assign cfg.valid   = cfg_valid_i;
  assign cfg.index   = cfg_index_i;
  assign cfg.data    = cfg_data_i;
  assign accept      = push && !full;

  // decode and escape state
  bed_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .accept_i      (accept),
    .has_byte_i    (has_byte_i),
    .data_byte_i   (data_byte_i),
    .arg_end_i     (arg_end_i),
    .message_end_i (message_end_i),
    .run_valid_o   (run_valid),
    .run_o         (wr_run)
  );

  // runs waiting for the back end
  bed_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (run_valid),
    .wr_data_i (wr_run),
    .full_o    (full),
    .rd_en_i   (run_pop),
    .rd_data_o (head_run),
    .empty_o   (run_empty)
  );

  // byte serializer
  bed_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .run_i          (head_run),
    .run_empty_i    (run_empty),
    .run_pop_o      (run_pop),
    .pop            (pop),
    .empty          (empty),
    .out_byte_o     (out_byte_o),
    .last_of_run_o  (last_of_run_o),
    .message_done_o (message_done_o)
  );

endmodule

### rtl/bed_front.sv
// front end: accepts items, holds escape state and config, builds one run per item
// depends on bed_pkg
module bed_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bed_pkg::cfg_wr_t  cfg_i,
  input  logic              accept_i,
  input  logic              has_byte_i,
  input  logic [7:0]        data_byte_i,
  input  logic              arg_end_i,
  input  logic              message_end_i,
  output logic              run_valid_o,
  output bed_pkg::run_t     run_o
);

  logic       interp_q, newline_q;
  logic       esc_q, esc_d;
  logic [1:0] digits_q, digits_d;
  logic [7:0] acc_q, acc_d;
  logic       hex_q, hex_d;
  logic       stop_q, stop_d;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interp_q  <= 1'b0;
      newline_q <= 1'b1;
    end else if (cfg_i.valid) begin
      if (cfg_i.index == bed_pkg::RegInterpret) interp_q <= cfg_i.data;
      if (cfg_i.index == bed_pkg::RegNewline)   newline_q <= cfg_i.data;
    end
  end

  // decode of one item into up to three bytes
  always_comb begin
    logic [bed_pkg::MaxRun-1:0][7:0] bytes;
    logic [1:0]                      n;
    logic                            last;
    bed_pkg::digit_t                 dg;
    bed_pkg::ctrl_t                  ct;
    bytes    = '0;
    n        = 2'd0;
    last     = arg_end_i & message_end_i;
    dg       = bed_pkg::digit_value(data_byte_i, hex_q);
    ct       = bed_pkg::ctrl_letter(data_byte_i);
    esc_d    = esc_q;
    digits_d = digits_q;
    acc_d    = acc_q;
    hex_d    = hex_q;
    stop_d   = stop_q;

    if (!stop_q && has_byte_i) begin
      if (!esc_q) begin
        if (interp_q && data_byte_i == bed_pkg::ChBackslash) begin
          esc_d = 1'b1;
        end else begin
          bytes[n] = data_byte_i;
          n = n + 2'd1;
        end
      end else if (digits_q != 2'd0) begin
        // numeric escape in progress
        if (dg.hit) begin
          acc_d    = hex_q ? {acc_q[3:0], dg.val} : {acc_q[4:0], dg.val[2:0]};
          digits_d = digits_q - 2'd1;
        end else begin
          digits_d = 2'd0;
        end
        if (digits_d == 2'd0) begin
          bytes[n] = acc_d;
          n = n + 2'd1;
          esc_d  = 1'b0;
          acc_d  = 8'd0;
          if (!dg.hit) begin
            bytes[n] = data_byte_i;
            n = n + 2'd1;
          end
        end
      end else if (ct.hit) begin
        esc_d    = 1'b0;
        bytes[n] = ct.val;
        n = n + 2'd1;
      end else if (data_byte_i == bed_pkg::ChStop) begin
        esc_d    = 1'b0;
        digits_d = 2'd0;
        acc_d    = 8'd0;
        stop_d   = 1'b1;
      end else if (data_byte_i == bed_pkg::ChOctal) begin
        hex_d    = 1'b0;
        digits_d = bed_pkg::OctDigits;
        acc_d    = 8'd0;
      end else if (data_byte_i == bed_pkg::ChHex) begin
        hex_d    = 1'b1;
        digits_d = bed_pkg::HexDigits;
        acc_d    = 8'd0;
      end else begin
        // unknown escape keeps its backslash
        esc_d    = 1'b0;
        bytes[n] = bed_pkg::ChBackslash;
        n = n + 2'd1;
        bytes[n] = data_byte_i;
        n = n + 2'd1;
      end
    end

    // argument close: flush escape, then separator or newline
    if (!stop_d && arg_end_i) begin
      if (esc_d) begin
        bytes[n] = (digits_d != 2'd0) ? acc_d : bed_pkg::ChBackslash;
        n = n + 2'd1;
      end
      if (!last) begin
        bytes[n] = bed_pkg::ChSpace;
        n = n + 2'd1;
      end else if (newline_q) begin
        bytes[n] = bed_pkg::ChNewline;
        n = n + 2'd1;
      end
    end

    if (arg_end_i) begin
      esc_d    = 1'b0;
      digits_d = 2'd0;
      acc_d    = 8'd0;
    end
    if (last) begin
      stop_d = 1'b0;
      hex_d  = 1'b0;
    end

    run_valid_o = accept_i && (n != 2'd0);
    run_o.cnt   = n;
    run_o.bytes = bytes;
    run_o.done  = last;
  end

  // escape state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      esc_q    <= 1'b0;
      digits_q <= 2'd0;
      acc_q    <= 8'd0;
      hex_q    <= 1'b0;
      stop_q   <= 1'b0;
    end else if (accept_i) begin
      esc_q    <= esc_d;
      digits_q <= digits_d;
      acc_q    <= acc_d;
      hex_q    <= hex_d;
      stop_q   <= stop_d;
    end
  end

endmodule

### rtl/bed_queue.sv
// short run queue between front and back
// depends on bed_pkg
module bed_queue #(
  parameter int unsigned Depth = bed_pkg::QueueDepth  // 2 or more
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_en_i,
  input  bed_pkg::run_t wr_data_i,
  output logic          full_o,
  input  logic          rd_en_i,
  output bed_pkg::run_t rd_data_o,
  output logic          empty_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  bed_pkg::run_t mem_q [Depth];
  logic [PtrW-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            wr, rd;

  assign full_o    = (cnt_q == CntW'(Depth));
  assign empty_o   = (cnt_q == '0);
  assign rd_data_o = mem_q[rptr_q];
  assign wr        = wr_en_i && !full_o;
  assign rd        = rd_en_i && !empty_o;

  // pointer and fill count update
  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (wr) wptr_d = (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + PtrW'(1);
    if (rd) rptr_d = (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + PtrW'(1);
    if (wr && !rd) cnt_d = cnt_q + CntW'(1);
    else if (rd && !wr) cnt_d = cnt_q - CntW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wptr_q] <= wr_data_i;
  end

endmodule

### rtl/bed_back.sv
// back end: walks the head run byte by byte onto the result ports
// depends on bed_pkg
module bed_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  bed_pkg::run_t run_i,
  input  logic          run_empty_i,
  output logic          run_pop_o,
  input  logic          pop,
  output logic          empty,
  output logic [7:0]    out_byte_o,
  output logic          last_of_run_o,
  output logic          message_done_o
);

  logic [1:0] idx_q, idx_d;
  logic       beat, last;

  assign empty          = run_empty_i;
  assign out_byte_o     = run_i.bytes[idx_q];
  assign last           = (idx_q == run_i.cnt - 2'd1);
  assign last_of_run_o  = last;
  assign message_done_o = last && run_i.done;
  assign beat           = pop && !run_empty_i;
  assign run_pop_o      = beat && last;

  // byte index within the head run
  always_comb begin
    idx_d = idx_q;
    if (beat) idx_d = last ? 2'd0 : idx_q + 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) idx_q <= 2'd0;
    else         idx_q <= idx_d;
  end

endmodule

### rtl/bed_checker.sv
// port-level checks of the backslash escape decoder, bound to the top level
// depends on backslash_escape_decoder
module bed_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       push,
  input logic       full,
  input logic       empty,
  input logic       pop,
  input logic [7:0] out_byte_o,
  input logic       last_of_run_o,
  input logic       message_done_o
);

  // message end only ever marks the closing byte of a run
  a_done_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && message_done_o) |-> last_of_run_o)
    else $error("message_done without last_of_run");

  // a waiting result holds until taken
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(out_byte_o) && $stable(last_of_run_o)))
    else $error("result changed while stalled");

  // nothing appears without an input beat
  a_no_invent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (empty && !(push && !full)) |=> empty)
    else $error("result without an input beat");

  // queue stays full until a result beat frees a run
  a_full_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (full && !(pop && !empty)) |=> full)
    else $error("full dropped without a result beat");

endmodule

bind backslash_escape_decoder bed_checker u_bed_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .push           (push),
  .full           (full),
  .empty          (empty),
  .pop            (pop),
  .out_byte_o     (out_byte_o),
  .last_of_run_o  (last_of_run_o),
  .message_done_o (message_done_o)
);
